[rtl/rmq_pkg.sv]
// Package with shared types, constants and saturation helpers for the matrix-to-quaternion block.
package rmq_pkg;

  // One Q2.14 matrix or quaternion element.
  typedef logic signed [15:0] q_t;

  // Width of an exact sum or difference of two elements.
  localparam int DIFW = 17;

  // Which quaternion component is taken from the square root.
  typedef enum logic [1:0] {
    PIV_X = 2'd0,
    PIV_Y = 2'd1,
    PIV_Z = 2'd2,
    PIV_W = 2'd3
  } piv_t;

  // The nine matrix elements of one word, column by column.
  typedef struct packed {
    q_t fwd_x;
    q_t fwd_y;
    q_t fwd_z;
    q_t right_x;
    q_t right_y;
    q_t right_z;
    q_t up_x;
    q_t up_y;
    q_t up_z;
  } mat_t;

  localparam logic [63:0] POS_LIMIT = 64'd32767;
  localparam logic [63:0] NEG_LIMIT = 64'd32768;

  // Clamps a magnitude with its sign to the 16-bit signed range.
  function automatic q_t sat_mag(input logic [63:0] mag, input logic neg);
    q_t res;
    if (!neg) begin
      res = (mag > POS_LIMIT) ? 16'sh7fff : q_t'(mag[15:0]);
    end else begin
      res = (mag > NEG_LIMIT) ? 16'sh8000 : q_t'(-mag[15:0]);
    end
    return res;
  endfunction

endpackage

[rtl/rmq_if.sv]
// Valid/ready channel interfaces for the matrix input and the quaternion output.
interface rmq_mat_if;
  logic valid;
  logic ready;
  logic signed [15:0] fwd_x;
  logic signed [15:0] fwd_y;
  logic signed [15:0] fwd_z;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic signed [15:0] right_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;
  modport source (output valid, fwd_x, fwd_y, fwd_z, right_x, right_y, right_z,
                  up_x, up_y, up_z, input ready);
  modport sink (input valid, fwd_x, fwd_y, fwd_z, right_x, right_y, right_z,
                up_x, up_y, up_z, output ready);
endinterface

interface rmq_quat_if;
  logic valid;
  logic ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic degenerate;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, degenerate, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, degenerate, output ready);
endinterface

[rtl/rmq_front.sv]
// Front stage: trace, pivot choice, root argument and the three element differences.
module rmq_front #(
  parameter int FRAC_BITS = 14,
  parameter int AW = 19,
  parameter int RADW = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  rmq_pkg::mat_t mat,
  output logic out_valid,
  output logic [RADW-1:0] rad,
  output rmq_pkg::piv_t piv,
  output logic degen,
  output logic signed [rmq_pkg::DIFW-1:0] da,
  output logic signed [rmq_pkg::DIFW-1:0] db,
  output logic signed [rmq_pkg::DIFW-1:0] dc
);
  import rmq_pkg::*;

  logic signed [AW-1:0] e00, e11, e22, one_v, tr, arg_p, arg_s;
  logic signed [DIFW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [DIFW-1:0] da_n, db_n, dc_n;
  logic trace_pos, degen_n;
  piv_t piv_n, piv_big;
  logic [RADW-1:0] rad_n;

  // Sign-extended elements.
  always_comb begin
    m00 = DIFW'(mat.fwd_x);
    m10 = DIFW'(mat.fwd_y);
    m20 = DIFW'(mat.fwd_z);
    m01 = DIFW'(mat.right_x);
    m11 = DIFW'(mat.right_y);
    m21 = DIFW'(mat.right_z);
    m02 = DIFW'(mat.up_x);
    m12 = DIFW'(mat.up_y);
    m22 = DIFW'(mat.up_z);
    e00 = AW'(mat.fwd_x);
    e11 = AW'(mat.right_y);
    e22 = AW'(mat.up_z);
    one_v = AW'(1) <<< FRAC_BITS;
    tr = e00 + e11 + e22;
    trace_pos = !tr[AW-1] && (tr != '0);
  end

  // Largest diagonal element with strict-less ties, and its root argument.
  always_comb begin
    if (e00 < e11) begin
      piv_big = (e11 < e22) ? PIV_Z : PIV_Y;
    end else begin
      piv_big = (e00 < e22) ? PIV_Z : PIV_X;
    end
    case (piv_big)
      PIV_X: begin
        arg_p = e00 - e11 - e22 + one_v;
      end
      PIV_Y: begin
        arg_p = e11 - e22 - e00 + one_v;
      end
      default: begin
        arg_p = e22 - e00 - e11 + one_v;
      end
    endcase
  end

  // Branch selection and the differences that feed the dividers.
  always_comb begin
    piv_n = trace_pos ? PIV_W : piv_big;
    case (piv_n)
      PIV_X: begin
        da_n = m21 - m12;
        db_n = m10 + m01;
        dc_n = m20 + m02;
      end
      PIV_Y: begin
        da_n = m02 - m20;
        db_n = m21 + m12;
        dc_n = m01 + m10;
      end
      PIV_Z: begin
        da_n = m10 - m01;
        db_n = m02 + m20;
        dc_n = m12 + m21;
      end
      default: begin
        da_n = m21 - m12;
        db_n = m02 - m20;
        dc_n = m10 - m01;
      end
    endcase
    arg_s = trace_pos ? (tr + one_v) : arg_p;
    degen_n = !trace_pos && (arg_s[AW-1] || (arg_s == '0));
    rad_n = degen_n ? '0 : (RADW'(arg_s[AW-2:0]) << FRAC_BITS);
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad <= rad_n;
      piv <= piv_n;
      degen <= degen_n;
      da <= da_n;
      db <= db_n;
      dc <= dc_n;
    end
  end

endmodule

[rtl/rmq_sqrt.sv]
// Pipelined integer square root, one root bit per register stage.
module rmq_sqrt #(
  parameter int SW = 16,
  parameter int SIDEW = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [2*SW-1:0] rad,
  input  logic [SIDEW-1:0] side_in,
  output logic out_valid,
  output logic [SW-1:0] root,
  output logic [SIDEW-1:0] side_out
);
  localparam int RMW = SW + 2;

  logic [RMW-1:0] rem_r [SW];
  logic [SW-1:0] root_r [SW];
  logic [2*SW-1:0] rad_r [SW];
  logic [SIDEW-1:0] side_r [SW];
  logic [SW-1:0] vld_r;

  for (genvar g = 0; g < SW; g++) begin : g_stage
    logic [RMW-1:0] rem_p, rem_sh, trial;
    logic [SW-1:0] root_p;
    logic [2*SW-1:0] rad_p;
    logic [SIDEW-1:0] side_p;
    logic vld_p, take;

    // Previous stage, or the input for the first one.
    always_comb begin
      if (g == 0) begin
        rem_p = '0;
        root_p = '0;
        rad_p = rad;
        side_p = side_in;
        vld_p = in_valid;
      end else begin
        rem_p = rem_r[(g == 0) ? 0 : g-1];
        root_p = root_r[(g == 0) ? 0 : g-1];
        rad_p = rad_r[(g == 0) ? 0 : g-1];
        side_p = side_r[(g == 0) ? 0 : g-1];
        vld_p = vld_r[(g == 0) ? 0 : g-1];
      end
      rem_sh = {rem_p[RMW-3:0], rad_p[2*SW-1 -: 2]};
      trial = {root_p, 2'b01};
      take = (rem_sh >= trial);
    end

    // One digit of the root.
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= take ? (rem_sh - trial) : rem_sh;
        root_r[g] <= {root_p[SW-2:0], take};
        rad_r[g] <= rad_p << 2;
        side_r[g] <= side_p;
      end
    end
  end

  assign out_valid = vld_r[SW-1];
  assign root = root_r[SW-1];
  assign side_out = side_r[SW-1];

endmodule

[rtl/rmq_div.sv]
// Three-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
module rmq_div #(
  parameter int NW = 32,
  parameter int DENW = 17,
  parameter int SIDEW = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [2:0][NW-1:0] num,
  input  logic [DENW-1:0] den,
  input  logic [SIDEW-1:0] side_in,
  output logic out_valid,
  output logic [2:0][NW-1:0] quo,
  output logic [SIDEW-1:0] side_out
);
  localparam int RW = DENW + 1;

  logic [2:0][RW-1:0] rem_r [NW];
  logic [2:0][NW-1:0] num_r [NW];
  logic [2:0][NW-1:0] quo_r [NW];
  logic [DENW-1:0] den_r [NW];
  logic [SIDEW-1:0] side_r [NW];
  logic [NW-1:0] vld_r;

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic [2:0][RW-1:0] rem_p, rem_n;
    logic [2:0][NW-1:0] num_p, quo_p, quo_n;
    logic [DENW-1:0] den_p;
    logic [SIDEW-1:0] side_p;
    logic vld_p;

    // Previous stage, or the input for the first one.
    always_comb begin
      if (g == 0) begin
        rem_p = '0;
        num_p = num;
        quo_p = '0;
        den_p = den;
        side_p = side_in;
        vld_p = in_valid;
      end else begin
        rem_p = rem_r[(g == 0) ? 0 : g-1];
        num_p = num_r[(g == 0) ? 0 : g-1];
        quo_p = quo_r[(g == 0) ? 0 : g-1];
        den_p = den_r[(g == 0) ? 0 : g-1];
        side_p = side_r[(g == 0) ? 0 : g-1];
        vld_p = vld_r[(g == 0) ? 0 : g-1];
      end
    end

    // Shift in one numerator bit per lane and subtract where it fits.
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        logic [RW-1:0] sh;
        logic fit;
        sh = {rem_p[l][RW-2:0], num_p[l][NW-1]};
        fit = (sh >= {1'b0, den_p});
        rem_n[l] = fit ? (sh - {1'b0, den_p}) : sh;
        quo_n[l] = {quo_p[l][NW-2:0], fit};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_n;
        num_r[g] <= {num_p[2] << 1, num_p[1] << 1, num_p[0] << 1};
        quo_r[g] <= quo_n;
        den_r[g] <= den_p;
        side_r[g] <= side_p;
      end
    end
  end

  assign out_valid = vld_r[NW-1];
  assign quo = quo_r[NW-1];
  assign side_out = side_r[NW-1];

endmodule

[rtl/rotation_matrix_to_quaternion.sv]
// Top level: rotation matrix to unit quaternion, Shepperd trace method, Q2.14 pipeline.
//
//  channel  direction  word                                        handshake
//  matrix   in         fwd_*, right_*, up_* (9 x 16-bit signed)    valid/ready
//  quat     out        quat_w/x/y/z (16-bit signed), degenerate    valid/ready
//
// One word enters per clock unless the output stalls; the square root resolves one root
// bit per stage and the divider one quotient bit per stage. The whole pipeline advances
// together whenever the output register is empty or being taken, so a stall holds every
// stage in place. Reset (rst, synchronous) clears only the valid bits.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 14
) (
  input logic clk,
  input logic rst,
  rmq_mat_if.sink matrix,
  rmq_quat_if.source quat
);
  import rmq_pkg::*;

  localparam int AW = (FRAC_BITS > 16) ? FRAC_BITS + 3 : 19;
  localparam int RW = AW - 1 + FRAC_BITS;
  localparam int SW = (RW + 1) / 2;
  localparam int NW = DIFW + 1 + FRAC_BITS;
  localparam int S1W = 2 + 1 + 3 * DIFW;
  localparam int S2W = 2 + 1 + 3 + SW;

  logic en;
  mat_t mat;
  logic f_valid, f_degen;
  logic [2*SW-1:0] f_rad;
  piv_t f_piv;
  logic signed [DIFW-1:0] f_da, f_db, f_dc;
  logic r_valid;
  logic [SW-1:0] r_root;
  logic [S1W-1:0] r_side;

  // The pipeline moves whenever the output register can take a word.
  assign en = !quat.valid || quat.ready;
  assign matrix.ready = en;

  always_comb begin
    mat.fwd_x = matrix.fwd_x;
    mat.fwd_y = matrix.fwd_y;
    mat.fwd_z = matrix.fwd_z;
    mat.right_x = matrix.right_x;
    mat.right_y = matrix.right_y;
    mat.right_z = matrix.right_z;
    mat.up_x = matrix.up_x;
    mat.up_y = matrix.up_y;
    mat.up_z = matrix.up_z;
  end

  rmq_front #(.FRAC_BITS(FRAC_BITS), .AW(AW), .RADW(2*SW)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(matrix.valid), .mat(mat),
    .out_valid(f_valid), .rad(f_rad), .piv(f_piv), .degen(f_degen),
    .da(f_da), .db(f_db), .dc(f_dc)
  );

  rmq_sqrt #(.SW(SW), .SIDEW(S1W)) u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_valid), .rad(f_rad),
    .side_in({f_piv, f_degen, f_da, f_db, f_dc}),
    .out_valid(r_valid), .root(r_root), .side_out(r_side)
  );

  // Scale stage: dividend |D| * 2^F + S per lane, divisor 2S, pivot (S+1)/2.
  logic signed [DIFW-1:0] r_d [3];
  logic [2:0][NW-1:0] num_n;
  logic [2:0] sg_n;
  logic [SW:0] hv_sum;
  logic c_valid;
  logic [2:0][NW-1:0] c_num;
  logic [SW:0] c_den;
  logic [S2W-1:0] c_side;

  always_comb begin
    r_d[0] = r_side[3*DIFW-1 -: DIFW];
    r_d[1] = r_side[2*DIFW-1 -: DIFW];
    r_d[2] = r_side[DIFW-1:0];
    for (int l = 0; l < 3; l++) begin
      logic [DIFW-1:0] mag;
      mag = r_d[l][DIFW-1] ? DIFW'(-r_d[l]) : DIFW'(r_d[l]);
      sg_n[l] = r_d[l][DIFW-1];
      num_n[l] = (NW'(mag) << FRAC_BITS) + NW'(r_root);
    end
    hv_sum = {1'b0, r_root} + (SW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_num <= num_n;
      c_den <= {r_root, 1'b0};
      c_side <= {r_side[S1W-1 -: 3], sg_n, hv_sum[SW:1]};
    end
  end

  logic d_valid;
  logic [2:0][NW-1:0] d_quo;
  logic [S2W-1:0] d_side;

  rmq_div #(.NW(NW), .DENW(SW+1), .SIDEW(S2W)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(c_valid), .num(c_num), .den(c_den),
    .side_in(c_side), .out_valid(d_valid), .quo(d_quo), .side_out(d_side)
  );

  // Output stage: saturate, place components by pivot, register the word.
  piv_t o_piv;
  logic o_degen;
  logic [2:0] o_sg;
  q_t qa, qb, qc, qh;
  q_t w_n, x_n, y_n, z_n;

  always_comb begin
    o_piv = piv_t'(d_side[S2W-1 -: 2]);
    o_degen = d_side[S2W-3];
    o_sg = d_side[SW+2 -: 3];
    qa = sat_mag(64'(d_quo[0]), o_sg[0]);
    qb = sat_mag(64'(d_quo[1]), o_sg[1]);
    qc = sat_mag(64'(d_quo[2]), o_sg[2]);
    qh = sat_mag(64'(d_side[SW-1:0]), 1'b0);
    case (o_piv)
      PIV_X: begin
        w_n = qa; x_n = qh; y_n = qb; z_n = qc;
      end
      PIV_Y: begin
        w_n = qa; x_n = qc; y_n = qh; z_n = qb;
      end
      PIV_Z: begin
        w_n = qa; x_n = qb; y_n = qc; z_n = qh;
      end
      default: begin
        w_n = qh; x_n = qa; y_n = qb; z_n = qc;
      end
    endcase
    if (o_degen) begin
      w_n = '0; x_n = '0; y_n = '0; z_n = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quat.valid <= 1'b0;
    end else if (en) begin
      quat.valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat.quat_w <= w_n;
      quat.quat_x <= x_n;
      quat.quat_y <= y_n;
      quat.quat_z <= z_n;
      quat.degenerate <= o_degen;
    end
  end

  // A degenerate word carries an all-zero quaternion.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    quat.valid && quat.degenerate |->
      quat.quat_w == '0 && quat.quat_x == '0 && quat.quat_y == '0 && quat.quat_z == '0)
    else $error("degenerate word with nonzero quaternion");

  // An empty output register never blocks the input.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !quat.valid |-> matrix.ready)
    else $error("input stalled with empty output");

  // Reset leaves no word at the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !quat.valid)
    else $error("output valid after reset");

endmodule

[dv/rotation_matrix_to_quaternion_chk.sv]
// Checker that predicts and compares the quaternion words of the matrix-to-quaternion block.
module rotation_matrix_to_quaternion_chk #(
  parameter int FRAC_BITS = 14
) (
  input logic clk,
  input logic rst,
  rmq_mat_if matrix,
  rmq_quat_if quat,
  output int fail_count,
  output int pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rmq_pkg::*;

  typedef struct {
    q_t w;
    q_t x;
    q_t y;
    q_t z;
    logic degen;
  } quat_word_t;

  quat_word_t quat_queue[$];

  // Integer square root of a non-negative value, bit by bit.
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Scaled quotient d * 2^FRAC_BITS / (2*s), rounded half away from zero.
  function automatic longint scaled_quot(input longint d, input longint unsigned s);
    longint unsigned den;
    longint unsigned mag;
    longint r;
    den = s * 2;
    mag = longint'(d < 0 ? -d : d) << FRAC_BITS;
    r = longint'((mag + den / 2) / den);
    return d < 0 ? -r : r;
  endfunction

  function automatic q_t clamp16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return q_t'(v);
  endfunction

  // Trace method with pivot selection on the diagonal.
  function automatic quat_word_t predict_quat(input longint m[3][3]);
    quat_word_t e;
    longint q[4];
    longint tr;
    longint a;
    longint unsigned s;
    int i;
    int j;
    int k;
    longint one;
    one = longint'(1) << FRAC_BITS;
    q = '{0, 0, 0, 0};
    e.degen = 1'b0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      a = tr + one;
      s = root_floor(longint'(a) << FRAC_BITS);
      q[3] = longint'((s + 1) >> 1);
      q[0] = scaled_quot(m[2][1] - m[1][2], s);
      q[1] = scaled_quot(m[0][2] - m[2][0], s);
      q[2] = scaled_quot(m[1][0] - m[0][1], s);
    end else begin
      i = m[0][0] < m[1][1] ? (m[1][1] < m[2][2] ? 2 : 1) : (m[0][0] < m[2][2] ? 2 : 0);
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      a = m[i][i] - m[j][j] - m[k][k] + one;
      if (a <= 0) begin
        e.degen = 1'b1;
      end else begin
        s = root_floor(longint'(a) << FRAC_BITS);
        q[i] = longint'((s + 1) >> 1);
        q[3] = scaled_quot(m[k][j] - m[j][k], s);
        q[j] = scaled_quot(m[j][i] + m[i][j], s);
        q[k] = scaled_quot(m[k][i] + m[i][k], s);
      end
    end
    e.w = clamp16(q[3]);
    e.x = clamp16(q[0]);
    e.y = clamp16(q[1]);
    e.z = clamp16(q[2]);
    return e;
  endfunction

  // Predict on every accepted matrix word, compare every accepted quaternion word.
  always @(posedge clk) begin
    longint m[3][3];
    quat_word_t e;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (matrix.valid && matrix.ready) begin
        m[0][0] = matrix.fwd_x;   m[1][0] = matrix.fwd_y;   m[2][0] = matrix.fwd_z;
        m[0][1] = matrix.right_x; m[1][1] = matrix.right_y; m[2][1] = matrix.right_z;
        m[0][2] = matrix.up_x;    m[1][2] = matrix.up_y;    m[2][2] = matrix.up_z;
        quat_queue.push_back(predict_quat(m));
      end
      if (quat.valid && quat.ready) begin
        if (quat_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("ERROR: unexpected quaternion word");
        end else begin
          e = quat_queue.pop_front();
          if (quat.quat_w !== e.w || quat.quat_x !== e.x || quat.quat_y !== e.y ||
              quat.quat_z !== e.z || quat.degenerate !== e.degen) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("ERROR: expected w=%0d x=%0d y=%0d z=%0d dg=%0b, got %0d %0d %0d %0d %0b",
                       e.w, e.x, e.y, e.z, e.degen, quat.quat_w, quat.quat_x,
                       quat.quat_y, quat.quat_z, quat.degenerate);
          end
        end
      end
    end
    // Words still owed by the block.
    pending <= quat_queue.size();
  end
endmodule

[dv/rotation_matrix_to_quaternion_tb.sv]
// Testbench top: drives matrix words, stalls the quaternion side, and reports the verdict.
module rotation_matrix_to_quaternion_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmq_pkg::*;

  localparam int RANDOM_WORDS = 1400;
  localparam int IDLE_LIMIT = 5000;

  logic clk;
  logic rst;
  int fail_count;
  int pending;
  int idle_cycles;
  bit long_hold;
  bit stim_done;

  rmq_mat_if matrix ();
  rmq_quat_if quat ();

  rotation_matrix_to_quaternion uut (.clk(clk), .rst(rst), .matrix(matrix), .quat(quat));
  rotation_matrix_to_quaternion_chk chk (.clk(clk), .rst(rst), .matrix(matrix), .quat(quat),
                                         .fail_count(fail_count), .pending(pending));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Element chosen from extremes, unit values or noise.
  function automatic q_t pick_elem();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh4000;
      3: return -16'sh4000;
      default: return q_t'($urandom());
    endcase
  endfunction

  // Place a whole matrix word on the bus and hold it until accepted.
  task automatic send_word(input q_t e[9]);
    matrix.valid <= 1'b1;
    {matrix.fwd_x, matrix.fwd_y, matrix.fwd_z} <= {e[0], e[1], e[2]};
    {matrix.right_x, matrix.right_y, matrix.right_z} <= {e[3], e[4], e[5]};
    {matrix.up_x, matrix.up_y, matrix.up_z} <= {e[6], e[7], e[8]};
    @(posedge clk);
    while (!matrix.ready) @(posedge clk);
  endtask

  // Near-rotation matrix: signed permutation of unit columns with small noise.
  task automatic make_rotation(output q_t e[9]);
    int p;
    int c;
    int r;
    int rows[3];
    p = $urandom_range(0, 5);
    rows = '{p % 3, (p / 3 + p + 1) % 3, 0};
    if (rows[1] == rows[0]) rows[1] = (rows[0] + 1) % 3;
    rows[2] = 3 - rows[0] - rows[1];
    for (c = 0; c < 3; c++)
      for (r = 0; r < 3; r++)
        e[c * 3 + r] = q_t'((r == rows[c] ? ($urandom_range(0, 1) ? 16384 : -16384) : 0)
                            + int'($urandom_range(0, 8000)) - 4000);
  endtask

  task automatic idle_gap();
    matrix.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // Stimulus: directed corners, then random bursts.
  initial begin
    q_t e[9];
    int n;
    int burst;
    int d;
    rst <= 1'b1;
    stim_done = 1'b0;
    long_hold = 1'b0;
    matrix.valid <= 1'b0;
    {matrix.fwd_x, matrix.fwd_y, matrix.fwd_z} <= '0;
    {matrix.right_x, matrix.right_y, matrix.right_z} <= '0;
    {matrix.up_x, matrix.up_y, matrix.up_z} <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // Identity, each pivot branch, diagonal ties, extremes.
    e = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; send_word(e);
    e = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_word(e);
    e = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_word(e);
    e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_word(e);
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_word(e);
    e = '{-5000, 0, 0, 0, -5000, 0, 0, 0, -5000}; send_word(e);
    e = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}; send_word(e);
    e = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}; send_word(e);
    e = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    send_word(e);
    e = '{0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0}; send_word(e);
    e = '{-16384, 32767, 32767, 32767, -16384, 32767, 32767, 32767, 1}; send_word(e);
    e = '{1, 0, 0, 0, -1, 0, 0, 0, -1}; send_word(e);
    e = '{0, 1, 0, 0, -16383, 0, 0, 0, -16384}; send_word(e);
    // Hold the sender until every result is back.
    matrix.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    // Random bursts; a long receiver hold starts near the middle.
    n = 0;
    while (n < RANDOM_WORDS) begin
      burst = $urandom_range(1, 40);
      for (d = 0; d < burst && n < RANDOM_WORDS; d++) begin
        if ($urandom_range(0, 9) < 7) begin
          make_rotation(e);
        end else begin
          for (int t = 0; t < 9; t++) e[t] = pick_elem();
        end
        send_word(e);
        n++;
        if (n == RANDOM_WORDS / 2) long_hold = 1'b1;
      end
      if ($urandom_range(0, 2) != 0) idle_gap();
    end
    matrix.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stall pattern plus one long hold-off.
  initial begin
    int mode;
    bit held;
    held = 1'b0;
    quat.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold && !held) begin
        held = 1'b1;
        quat.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        quat.ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, mode) == 0);
        @(posedge clk);
      end
    end
  end

  // Watchdog and end of run.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((matrix.valid && matrix.ready) || (quat.valid && quat.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
      if (stim_done && pending == 0) begin
        repeat (80) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
          $display("*** PASSED ***");
        end else begin
          $display("*** FAILED ***");
        end
        $finish;
      end
    end
  end
endmodule
